// ===== sv/assert_macros.svh =====
// assertion macros used by stcf_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define STCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define STCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/stcf_pkg.sv =====
// ----------------------------------------------------------------------------
// stcf_pkg
// Shared constants, codes and types for the sorted table coincidence filter.
// ----------------------------------------------------------------------------
package stcf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ACT_W       = 2;
    localparam int EVT_W       = 31;
    localparam int DATA_W      = 32;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_HOLD
    } t_state;

    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;

    // probe index between left and right, right held as right + 1
    function automatic t_addr mid_of(input t_count left, input t_count right_p1);
        logic [CNT_W:0] sum;
        begin
            sum    = {1'b0, left} + {1'b0, right_p1} - {{CNT_W{1'b0}}, 1'b1};
            mid_of = sum[ADDR_W:1];
        end
    endfunction

endpackage

// ===== sv/stcf_if.sv =====
// ----------------------------------------------------------------------------
// stcf_if
// Handshake channels for query/load items and for matched results.
// ----------------------------------------------------------------------------
interface stcf_in_if;
    logic                         valid;
    logic                         ready;
    logic [stcf_pkg::ACT_W-1:0]   action;
    logic [stcf_pkg::EVT_W-1:0]   event_number;
    logic [stcf_pkg::DATA_W-1:0]  side_data;

    modport source (output valid, action, event_number, side_data, input ready);
    modport sink   (input valid, action, event_number, side_data, output ready);
endinterface

interface stcf_out_if;
    logic                         valid;
    logic                         ready;
    logic [stcf_pkg::EVT_W-1:0]   matched_event;
    logic [stcf_pkg::DATA_W-1:0]  matched_data;

    modport source (output valid, matched_event, matched_data, input ready);
    modport sink   (input valid, matched_event, matched_data, output ready);
endinterface

// ===== sv/stcf_ram.sv =====
// ----------------------------------------------------------------------------
// stcf_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module stcf_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sorted_table_coincidence_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_coincidence_filter_unit
// Keeps event numbers in RAM in load order (searched as if ascending) and
// passes query items whose event number a binary search finds in the table.
// ----------------------------------------------------------------------------
// clear and load items leave the unit in ST_IDLE, so ready stays high
// query: at most ceil(log2(n+1)) probes (11 on a full table); the result is
//   registered from the matching probe, or from ST_HOLD while the slot is busy
// a new item is taken only once back in ST_IDLE; the table has a single RAM port
// a stalled result holds off new items only after the next match is found
// reset (synchronous): entry count and control cleared, table contents kept
module sorted_table_coincidence_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stcf_in_if.sink    i_item,
    stcf_out_if.source o_match
);

    stcf_pkg::t_state r_state, n_state;
    stcf_pkg::t_count r_count, n_count;
    stcf_pkg::t_count r_left, n_left;
    stcf_pkg::t_count r_right_p1, n_right_p1;
    stcf_pkg::t_addr  r_mid, n_mid;
    logic [stcf_pkg::EVT_W-1:0]  r_key, n_key;
    logic [stcf_pkg::DATA_W-1:0] r_data, n_data;
    logic                        r_ovalid, n_ovalid;
    logic [stcf_pkg::EVT_W-1:0]  r_oevent, n_oevent;
    logic [stcf_pkg::DATA_W-1:0] r_odata, n_odata;

    logic                        accept;
    logic                        slot_free;
    logic                        hit;
    logic                        go_right;
    stcf_pkg::t_count            step_left;
    stcf_pkg::t_count            step_right_p1;
    logic                        ram_we;
    stcf_pkg::t_addr             ram_addr;
    logic [stcf_pkg::EVT_W-1:0]  ram_rdata;

    stcf_ram #(
        .WIDTH (stcf_pkg::EVT_W),
        .DEPTH (stcf_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_item.event_number),
        .o_rdata (ram_rdata)
    );

    assign i_item.ready = (r_state == stcf_pkg::ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign slot_free    = !r_ovalid || o_match.ready;

    assign hit           = (ram_rdata == r_key);
    assign go_right      = (ram_rdata < r_key);
    assign step_left     = go_right ? stcf_pkg::t_count'({1'b0, r_mid} + 1'b1) : r_left;
    assign step_right_p1 = go_right ? r_right_p1 : stcf_pkg::t_count'(r_mid);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stcf_pkg::ST_IDLE: begin
                if (accept && i_item.action == stcf_pkg::ACT_QUERY && r_count != '0) begin
                    n_state = stcf_pkg::ST_PROBE;
                end
            end
            stcf_pkg::ST_PROBE: begin
                if (hit) begin
                    n_state = slot_free ? stcf_pkg::ST_IDLE : stcf_pkg::ST_HOLD;
                end else if (step_left >= step_right_p1) begin
                    n_state = stcf_pkg::ST_IDLE;
                end
            end
            stcf_pkg::ST_HOLD: begin
                if (slot_free) begin
                    n_state = stcf_pkg::ST_IDLE;
                end
            end
            default: n_state = stcf_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count    = r_count;
        n_left     = r_left;
        n_right_p1 = r_right_p1;
        n_mid      = r_mid;
        n_key      = r_key;
        n_data     = r_data;
        n_ovalid   = r_ovalid && !o_match.ready;
        n_oevent   = r_oevent;
        n_odata    = r_odata;
        ram_we     = 1'b0;
        ram_addr   = r_count[stcf_pkg::ADDR_W-1:0];
        unique case (r_state)
            stcf_pkg::ST_IDLE: begin
                n_key  = i_item.event_number;
                n_data = i_item.side_data;
                if (accept) begin
                    case (i_item.action)
                        stcf_pkg::ACT_CLEAR: n_count = '0;
                        stcf_pkg::ACT_LOAD: begin
                            if (r_count < stcf_pkg::t_count'(stcf_pkg::TABLE_DEPTH)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        stcf_pkg::ACT_QUERY: begin
                            n_left     = '0;
                            n_right_p1 = r_count;
                            n_mid      = stcf_pkg::mid_of('0, r_count);
                            ram_addr   = n_mid;
                        end
                        default: ;
                    endcase
                end
            end
            stcf_pkg::ST_PROBE: begin
                if (hit) begin
                    if (slot_free) begin
                        n_ovalid = 1'b1;
                        n_oevent = r_key;
                        n_odata  = r_data;
                    end
                end else begin
                    n_left     = step_left;
                    n_right_p1 = step_right_p1;
                    n_mid      = stcf_pkg::mid_of(step_left, step_right_p1);
                    ram_addr   = n_mid;
                end
            end
            stcf_pkg::ST_HOLD: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oevent = r_key;
                    n_odata  = r_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stcf_pkg::ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_right_p1 <= n_right_p1;
        r_mid      <= n_mid;
        r_key      <= n_key;
        r_data     <= n_data;
        r_oevent   <= n_oevent;
        r_odata    <= n_odata;
    end

    assign o_match.valid         = r_ovalid;
    assign o_match.matched_event = r_oevent;
    assign o_match.matched_data  = r_odata;

endmodule

// ===== sv/stcf_checker.sv =====
// ----------------------------------------------------------------------------
// stcf_checker
// Port-level checks of the coincidence filter, bound to the filter unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stcf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [stcf_pkg::ACT_W-1:0]  i_in_action,
    input logic                        i_out_valid,
    input logic                        i_out_ready
);

    logic in_take;
    logic non_query;

    assign in_take   = i_in_valid && i_in_ready;
    assign non_query = (i_in_action != stcf_pkg::ACT_QUERY);

    `STCF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `STCF_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result shown after reset")
    `STCF_ASSERT(a_load_fast, i_clk, i_rst_n, in_take && !non_query == 1'b0 |=> i_in_ready, "load or clear not done in one cycle")
    `STCF_ASSERT(a_no_spurious, i_clk, i_rst_n, in_take && non_query |=> !$rose(i_out_valid), "result from a load or clear")

endmodule

bind sorted_table_coincidence_filter_unit stcf_checker u_stcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_action (i_item.action),
    .i_out_valid (o_match.valid),
    .i_out_ready (o_match.ready)
);

// ===== tb/sv/stcf_match_checker.sv =====
// ----------------------------------------------------------------------------
// stcf_match_checker
// Watches the item and match channels of the coincidence filter, keeps its own
// copy of the loaded event table, predicts which queries must pass, and
// compares every accepted match, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module stcf_match_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    stcf_in_if   i_item,
    stcf_out_if  i_match,
    output int   o_fail_count,
    output int   o_pending
);
    import stcf_pkg::*;

    typedef struct packed {
        logic [EVT_W-1:0]  evt;
        logic [DATA_W-1:0] data;
    } t_match;

    logic [EVT_W-1:0] loaded_events [TABLE_DEPTH];
    int               loaded_count = 0;
    t_match           pending_matches [$];
    int               fails = 0;

    // binary search over the loaded entries, inclusive bounds
    function automatic bit event_in_table(input logic [EVT_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = loaded_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (loaded_events[mid] == key)
                return 1'b1;
            if (loaded_events[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            loaded_count = 0;
            pending_matches.delete();
        end else begin
            if (i_match.valid && i_match.ready) begin
                if (pending_matches.size() == 0) begin
                    $error("unexpected match: matched_event %0h, matched_data %0h",
                           i_match.matched_event, i_match.matched_data);
                    fails++;
                end else begin
                    want = pending_matches.pop_front();
                    if (i_match.matched_event !== want.evt) begin
                        $error("matched_event: expected %0h, actual %0h",
                               want.evt, i_match.matched_event);
                        fails++;
                    end
                    if (i_match.matched_data !== want.data) begin
                        $error("matched_data: expected %0h, actual %0h",
                               want.data, i_match.matched_data);
                        fails++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                case (i_item.action)
                    ACT_CLEAR: loaded_count = 0;
                    ACT_LOAD: begin
                        if (loaded_count < TABLE_DEPTH) begin
                            loaded_events[loaded_count] = i_item.event_number;
                            loaded_count++;
                        end
                    end
                    ACT_QUERY: begin
                        if (event_in_table(i_item.event_number)) begin
                            want.evt  = i_item.event_number;
                            want.data = i_item.side_data;
                            pending_matches = {pending_matches, want};
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_matches.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives clear, load and query items into the coincidence filter with random
// gaps and result stalls: a directed opening, one full-table run with loads
// past the end, then random load-and-search sequences with noise mixed in.
// ----------------------------------------------------------------------------
module tb;
    import stcf_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE    = 2'd3;
    localparam logic [EVT_W-1:0] EVT_MAX      = '1;
    localparam int               RANDOM_ITEMS = 1100;
    localparam int               DRAIN_CYCLES = 40;
    localparam int               STALL_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;
    int               items_sent = 0;
    logic [EVT_W-1:0] shadow_events [$];

    stcf_in_if  item_bus ();
    stcf_out_if match_bus ();

    sorted_table_coincidence_filter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_match (match_bus)
    );

    stcf_match_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_match      (match_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [EVT_W-1:0] evt,
                             input logic [DATA_W-1:0] data);
        int gap;
        gap = draw_wait(tx_calm);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.action       <= act;
        item_bus.event_number <= evt;
        item_bus.side_data    <= data;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        case (act)
            ACT_CLEAR: shadow_events.delete();
            ACT_LOAD: begin
                if (shadow_events.size() < TABLE_DEPTH)
                    shadow_events = {shadow_events, evt};
            end
            default: ;
        endcase
        if (act != ACT_SPARE)
            items_sent++;
    endtask

    // mostly loaded numbers, some neighbours, extremes and random numbers
    function automatic logic [EVT_W-1:0] pick_query_event();
        int unsigned      sel;
        logic [EVT_W-1:0] e;
        sel = $urandom_range(0, 9);
        e   = EVT_W'($urandom());
        if (shadow_events.size() != 0 && sel < 8) begin
            e = shadow_events[$urandom_range(0, shadow_events.size() - 1)];
            if (sel == 6)
                e = $urandom_range(0, 1) ? e + 1'b1 : e - 1'b1;
            else if (sel == 7)
                e = $urandom_range(0, 1) ? EVT_MAX : '0;
        end
        return e;
    endfunction

    task automatic load_ascending(input int n, input int unsigned step_max);
        longint unsigned v;
        int              i;
        v = ($urandom_range(0, 3) == 0) ? longint'($urandom() >> 1) : $urandom_range(0, 1000);
        for (i = 0; i < n; i++) begin
            send_item(ACT_LOAD, v[EVT_W-1:0], $urandom());
            v = v + $urandom_range(0, step_max);
            if (v > EVT_MAX)
                v = EVT_MAX;
        end
    endtask

    task automatic query_burst(input int m);
        int i;
        for (i = 0; i < m; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_SPARE, pick_query_event(), $urandom());
            send_item(ACT_QUERY, pick_query_event(), $urandom());
        end
    endtask

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 3))
            0:       return 3;
            1:       return 1000;
            2:       return 32'h0010_0000;
            default: return 32'h0400_0000;
        endcase
    endfunction

    // result side may stall for a random hold after each accepted match
    initial begin : result_drain
        int hold;
        match_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        match_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (match_bus.valid && match_bus.ready) begin
                hold = draw_wait(rx_calm);
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                if (hold > 0) begin
                    match_bus.ready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                    match_bus.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_bus.valid && item_bus.ready) || (match_bus.valid && match_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int n;
        int i;
        i_rst_n               <= 1'b0;
        item_bus.valid        <= 1'b0;
        item_bus.action       <= ACT_CLEAR;
        item_bus.event_number <= '0;
        item_bus.side_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table and unused action, then a small table, its queries and a clear
        send_item(ACT_QUERY, '0, 32'h1234_5678);
        send_item(ACT_SPARE, '0, '0);
        send_item(ACT_LOAD, '0, '0);
        send_item(ACT_LOAD, 31'd5, '1);
        send_item(ACT_LOAD, EVT_MAX, 32'h5555_5555);
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_QUERY, EVT_MAX, '1);
        send_item(ACT_QUERY, 31'd5, 32'hAAAA_AAAA);
        send_item(ACT_QUERY, 31'd6, 32'h0000_0001);
        send_item(ACT_QUERY, EVT_MAX - 1'b1, 32'h8000_0000);
        send_item(ACT_SPARE, 31'd6, '1);
        send_item(ACT_QUERY, 31'd5, 32'h7FFF_FFFF);
        send_item(ACT_CLEAR, EVT_MAX, '1);
        send_item(ACT_QUERY, 31'd5, 32'hDEAD_BEEF);
        // unsorted loads, the search misses the first entry
        send_item(ACT_LOAD, 31'd9, '0);
        send_item(ACT_LOAD, 31'd3, '0);
        send_item(ACT_LOAD, 31'd7, '0);
        send_item(ACT_QUERY, 31'd3, 32'h0F0F_0F0F);
        send_item(ACT_QUERY, 31'd9, 32'hF0F0_F0F0);
        send_item(ACT_QUERY, 31'd7, 32'h3C3C_3C3C);
        send_item(ACT_CLEAR, '0, '0);

        // full table, then loads that must be dropped, then queries
        load_ascending(TABLE_DEPTH, 32'h001F_FFFF);
        send_item(ACT_LOAD, EVT_W'($urandom()), $urandom());
        send_item(ACT_LOAD, '0, $urandom());
        send_item(ACT_QUERY, shadow_events[0], $urandom());
        send_item(ACT_QUERY, shadow_events[TABLE_DEPTH-1], $urandom());
        send_item(ACT_QUERY, shadow_events[TABLE_DEPTH/2], $urandom());
        query_burst(40);

        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
            if (kind <= 5) begin
                send_item(ACT_CLEAR, EVT_W'($urandom()), $urandom());
                load_ascending(n, pick_step());
                query_burst($urandom_range(4, 20));
            end else if (kind == 6) begin
                load_ascending(n, pick_step());
                query_burst($urandom_range(4, 12));
            end else if (kind == 7) begin
                send_item(ACT_CLEAR, EVT_W'($urandom()), $urandom());
                for (i = 0; i < n; i++)
                    send_item(ACT_LOAD, EVT_W'($urandom_range(0, 63)), $urandom());
                query_burst($urandom_range(4, 16));
            end else if (kind == 8) begin
                send_item(ACT_CLEAR, EVT_W'($urandom()), $urandom());
                query_burst($urandom_range(1, 4));
            end else begin
                for (i = 0; i < 8; i++)
                    send_item(ACT_W'($urandom_range(0, 3)), pick_query_event(), $urandom());
            end
        end
        item_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
